>>> sv/csqrt_pkg.sv
// Package for the CORDIC integer square root block.
// Holds the datapath widths, the reset offset and the cell schedule functions.
// Used by every module of the block; depends on nothing.
`default_nettype none

package csqrt_pkg;

    localparam int RADICAND_W   = 32;
    localparam int ROOT_W       = 16;
    localparam int LZ_W         = 5;
    localparam int HALF_E_W     = 4;
    localparam int FRAC_BITS    = 32;
    localparam int FIRST_REPEAT = 4;
    localparam int MAX_ITER     = 16;
    localparam int DEF_ITER     = 8;

    localparam logic [RADICAND_W-1:0] OFFSET_RESET = 32'hBAA11C87;

    // Mantissa plus parity shift is 33 bits; the sum with the offset and the
    // CORDIC growth over sixteen iterations stay inside 37 signed bits.
    localparam int P_W  = RADICAND_W + 1;
    localparam int XW   = 37;
    // After the smallest denormalizing shift the root fits in this many bits.
    localparam int MIN_SHIFT = FRAC_BITS - 15;
    localparam int XSW  = XW - MIN_SHIFT;
    localparam int SQ_W = 2 * XSW;

    typedef struct packed {
        logic [RADICAND_W-1:0] radicand;
        logic [HALF_E_W-1:0]   half_e;
        logic                  zero;
    } side_t;

    // Number of rotation cells, counting the repeated iterations.
    function automatic int num_cells(int iters);
        int n;
        int rep;
        n   = 0;
        rep = FIRST_REPEAT;
        for (int i = 1; i <= MAX_ITER; i++) begin
            if (i <= iters) begin
                n++;
                if (i == rep) begin
                    n++;
                    rep = 3 * rep + 1;
                end
            end
        end
        return n;
    endfunction

    // Shift amount of the cell at position idx in the chain.
    function automatic int cell_shift(int iters, int idx);
        int n;
        int rep;
        int s;
        n   = 0;
        rep = FIRST_REPEAT;
        s   = 1;
        for (int i = 1; i <= MAX_ITER; i++) begin
            if (i <= iters) begin
                if (n == idx) begin
                    s = i;
                end
                n++;
                if (i == rep) begin
                    if (n == idx) begin
                        s = i;
                    end
                    n++;
                    rep = 3 * rep + 1;
                end
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/csqrt_norm.sv
// Front end of the square root pipeline: leading-zero count, normalization
// and the starting x and y of the rotation chain. Two register stages.
// Depends on csqrt_pkg.
`default_nettype none

module csqrt_norm
    import csqrt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [RADICAND_W-1:0] radicand,
    input  wire logic [RADICAND_W-1:0] offset,
    output logic                       out_valid,
    output logic signed [XW-1:0]       out_x,
    output logic signed [XW-1:0]       out_y,
    output side_t                      out_side
);

    logic                  v1_reg;
    logic [RADICAND_W-1:0] r1_reg;
    logic [LZ_W-1:0]       lz1_reg;
    logic                  z1_reg;
    logic [LZ_W-1:0]       lz_next;

    logic                  v2_reg;
    logic signed [XW-1:0]  x2_reg;
    logic signed [XW-1:0]  y2_reg;
    side_t                 s2_reg;

    logic [RADICAND_W-1:0] mant;
    logic [LZ_W-1:0]       e;
    logic [P_W-1:0]        p;
    logic [XW-1:0]         px;
    logic [XW-1:0]         kx;

    // The highest set bit wins, as the last assignment of the loop.
    always_comb
    begin
        lz_next = '0;
        for (int i = 0; i < RADICAND_W; i++) begin
            if (radicand[i]) begin
                lz_next = LZ_W'(RADICAND_W - 1 - i);
            end
        end
    end

    always_comb
    begin
        mant = r1_reg << lz1_reg;
        e    = LZ_W'(RADICAND_W - 1) - lz1_reg;
        p    = {1'b0, mant} << e[0];
        px   = {{(XW - P_W){1'b0}}, p};
        kx   = {{(XW - RADICAND_W){1'b0}}, offset};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            r1_reg          <= radicand;
            lz1_reg         <= lz_next;
            z1_reg          <= (radicand == '0);
            x2_reg          <= $signed(px + kx);
            y2_reg          <= $signed(px - kx);
            s2_reg.radicand <= r1_reg;
            s2_reg.half_e   <= e[LZ_W-1:1];
            s2_reg.zero     <= z1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_x     = x2_reg;
    assign out_y     = y2_reg;
    assign out_side  = s2_reg;

endmodule

`default_nettype wire

>>> sv/csqrt_cell.sv
// One hyperbolic CORDIC rotation cell with a fixed shift amount.
// Registers x, y and the side data of the item passing through it.
// Depends on csqrt_pkg.
`default_nettype none

module csqrt_cell
    import csqrt_pkg::*;
#(
    parameter int SHIFT = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [XW-1:0] in_x,
    input  wire logic signed [XW-1:0] in_y,
    input  wire side_t                in_side,
    output logic                      out_valid,
    output logic signed [XW-1:0]      out_x,
    output logic signed [XW-1:0]      out_y,
    output side_t                     out_side
);

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    side_t                side_reg;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;

    // Direction follows the sign of y; both updates use the old x and y.
    always_comb
    begin
        dx = in_y >>> SHIFT;
        dy = in_x >>> SHIFT;
        if (in_y[XW-1]) begin
            x_next = in_x + dx;
            y_next = in_y + dy;
        end else begin
            x_next = in_x - dx;
            y_next = in_y - dy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

>>> sv/csqrt_final.sv
// Back end of the square root pipeline: denormalizing shift, squaring and
// the correction by one. Two register stages, then the compare.
// Depends on csqrt_pkg.
`default_nettype none

module csqrt_final
    import csqrt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [XW-1:0] in_x,
    input  wire side_t                in_side,
    output logic                      out_valid,
    output logic [ROOT_W-1:0]         out_root
);

    logic                   v1_reg;
    logic signed [XSW-1:0]  xs1_reg;
    side_t                  s1_reg;

    logic                   v2_reg;
    logic signed [XSW-1:0]  xs2_reg;
    logic signed [SQ_W-1:0] sq2_reg;
    side_t                  s2_reg;

    logic [5:0]             sh;
    logic signed [XW-1:0]   shifted;
    logic signed [SQ_W-1:0] rad_wide;
    logic                   dec;

    always_comb
    begin
        sh      = 6'(FRAC_BITS) - {2'b00, in_side.half_e};
        shifted = in_x >>> sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            xs1_reg <= shifted[XSW-1:0];
            s1_reg  <= in_side;
            xs2_reg <= xs1_reg;
            sq2_reg <= xs1_reg * xs1_reg;
            s2_reg  <= s1_reg;
        end
    end

    // Step back by one when the candidate squared exceeds the radicand.
    always_comb
    begin
        rad_wide = $signed({{(SQ_W - RADICAND_W){1'b0}}, s2_reg.radicand});
        dec      = (rad_wide < sq2_reg);
        if (s2_reg.zero) begin
            out_root = '0;
        end else begin
            out_root = xs2_reg[ROOT_W-1:0] - ROOT_W'(dec);
        end
    end

    assign out_valid = v2_reg;

endmodule

`default_nettype wire

>>> sv/cordic_integer_square_root.sv
// Integer square root of a 32-bit unsigned radicand by hyperbolic CORDIC.
// Top level: configuration register, pipeline assembly and output skid stage.
// Depends on csqrt_pkg, csqrt_norm, csqrt_cell and csqrt_final.
//
// The block takes one radicand per cycle while radicand_stall is low and
// returns its 16-bit root, the floor of the square root when start_offset
// matches ITERATIONS (the reset value suits eight). Results come out in order.
// An accepted radicand passes through csqrt_norm, the rotation chain, where
// each iteration has a cell and each repeated iteration (4 and 13) one more,
// csqrt_final and the output register. A two-entry output stage lets the
// pipeline keep taking radicands while a root waits; the input stalls only
// when both entries hold roots that have not been taken. The user must write
// start_offset only while no item is in flight; the block does not enforce it.
`default_nettype none

module cordic_integer_square_root
    import csqrt_pkg::*;
#(
    parameter int ITERATIONS = DEF_ITER
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start_offset_wr_en,
    input  wire logic [RADICAND_W-1:0] start_offset_wr_data,
    input  wire logic                  radicand_valid,
    output logic                       radicand_stall,
    input  wire logic [RADICAND_W-1:0] radicand,
    output logic                       root_valid,
    input  wire logic                  root_stall,
    output logic [ROOT_W-1:0]          root
);

    localparam int NCELLS = num_cells(ITERATIONS);

    logic [RADICAND_W-1:0] start_offset_reg;
    logic                  en;

    logic                  chain_valid [NCELLS+1];
    logic signed [XW-1:0]  chain_x     [NCELLS+1];
    logic signed [XW-1:0]  chain_y     [NCELLS+1];
    side_t                 chain_side  [NCELLS+1];

    logic                  res_valid;
    logic [ROOT_W-1:0]     res_root;

    logic                  out_valid_reg;
    logic [ROOT_W-1:0]     out_root_reg;
    logic                  skid_full_reg;
    logic [ROOT_W-1:0]     skid_root_reg;
    logic                  out_pop;
    logic                  incoming;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_offset_reg <= OFFSET_RESET;
        end else if (start_offset_wr_en) begin
            start_offset_reg <= start_offset_wr_data;
        end
    end

    // The whole pipeline moves together unless the skid entry is occupied.
    assign en             = !skid_full_reg;
    assign radicand_stall = skid_full_reg;

    csqrt_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (radicand_valid),
        .radicand  (radicand),
        .offset    (start_offset_reg),
        .out_valid (chain_valid[0]),
        .out_x     (chain_x[0]),
        .out_y     (chain_y[0]),
        .out_side  (chain_side[0])
    );

    for (genvar j = 0; j < NCELLS; j++) begin : g_cell
        csqrt_cell #(
            .SHIFT (cell_shift(ITERATIONS, j))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[j]),
            .in_x      (chain_x[j]),
            .in_y      (chain_y[j]),
            .in_side   (chain_side[j]),
            .out_valid (chain_valid[j+1]),
            .out_x     (chain_x[j+1]),
            .out_y     (chain_y[j+1]),
            .out_side  (chain_side[j+1])
        );
    end

    csqrt_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[NCELLS]),
        .in_x      (chain_x[NCELLS]),
        .in_side   (chain_side[NCELLS]),
        .out_valid (res_valid),
        .out_root  (res_root)
    );

    assign out_pop  = out_valid_reg && !root_stall;
    assign incoming = en && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (out_pop) begin
                skid_full_reg <= 1'b0;
            end
        end else if (incoming) begin
            if (out_valid_reg && !out_pop) begin
                skid_full_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg) begin
            if (out_pop) begin
                out_root_reg <= skid_root_reg;
            end
        end else if (incoming) begin
            if (out_valid_reg && !out_pop) begin
                skid_root_reg <= res_root;
            end else begin
                out_root_reg <= res_root;
            end
        end
    end

    assign root_valid = out_valid_reg;
    assign root       = out_root_reg;

endmodule

`default_nettype wire

>>> test/csqrt_root_checker.sv
// Checker for the CORDIC integer square root block: watches the offset port,
// the radicand channel and the root channel, predicts every root and compares.
// Depends on csqrt_pkg for the widths and the reset offset.
module csqrt_root_checker
    import csqrt_pkg::*;
#(
    parameter int ITERATIONS = DEF_ITER
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start_offset_wr_en,
    input  logic [RADICAND_W-1:0] start_offset_wr_data,
    input  logic                  radicand_valid,
    input  logic                  radicand_stall,
    input  logic [RADICAND_W-1:0] radicand,
    input  logic                  root_valid,
    input  logic                  root_stall,
    input  logic [ROOT_W-1:0]     root,
    output int                    mismatches,
    output int                    pending
);

    logic [RADICAND_W-1:0] offset_copy;
    logic [ROOT_W-1:0]     expected_roots [$];
    logic [ROOT_W-1:0]     wanted_root;

    // One hyperbolic shift-add step; both updates use the old x and y.
    function automatic void hyp_rotate(inout longint x, inout longint y, input int s);
        longint dx;
        longint dy;
        dx = y >>> s;
        dy = x >>> s;
        if (y < 0) begin
            x = x + dx;
            y = y + dy;
        end
        else begin
            x = x - dx;
            y = y - dy;
        end
    endfunction

    function automatic logic [ROOT_W-1:0] cordic_root(input logic [RADICAND_W-1:0] r,
                                                      input logic [RADICAND_W-1:0] offset);
        logic [RADICAND_W-1:0] mant;
        int                    lz;
        int                    expo;
        int                    rep;
        longint                x;
        longint                y;
        longint                sq;
        if (r == '0) begin
            return '0;
        end
        mant = r;
        lz   = 0;
        while (!mant[RADICAND_W-1]) begin
            mant = mant << 1;
            lz++;
        end
        expo = 31 - lz;
        x    = longint'(mant) << (expo & 1);
        y    = x - longint'(offset);
        x    = x + longint'(offset);
        rep  = FIRST_REPEAT;
        for (int i = 1; i <= ITERATIONS; i++) begin
            hyp_rotate(x, y, i);
            if (i == rep) begin
                hyp_rotate(x, y, i);
                rep = 3 * rep + 1;
            end
        end
        x  = x >>> (FRAC_BITS - (expo >> 1));
        sq = x * x;
        if (longint'(r) < sq) begin
            x = x - 1;
        end
        return ROOT_W'(x);
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            offset_copy = OFFSET_RESET;
        end
        else begin
            if (root_valid && !root_stall) begin
                if (expected_roots.size() == 0) begin
                    note_mismatch($sformatf("root %0d with no item outstanding", root));
                end
                else begin
                    wanted_root = expected_roots.pop_front();
                    if (root !== wanted_root) begin
                        note_mismatch($sformatf("root expected %0d, got %0d",
                                                wanted_root, root));
                    end
                end
            end
            if (radicand_valid && !radicand_stall) begin
                expected_roots.push_back(cordic_root(radicand, offset_copy));
            end
            if (start_offset_wr_en) begin
                offset_copy = start_offset_wr_data;
            end
            pending = expected_roots.size();
        end
    end

endmodule

>>> test/tb_cordic_integer_square_root.sv
// Testbench top for cordic_integer_square_root: clock, reset, radicand and
// offset stimulus, random receiver stalls and the verdict.
// Depends on csqrt_pkg, the block itself and csqrt_root_checker.
module tb_cordic_integer_square_root;
    import csqrt_pkg::*;

    localparam int RUN_LIMIT = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start_offset_wr_en;
    logic [RADICAND_W-1:0] start_offset_wr_data;
    logic                  radicand_valid;
    logic                  radicand_stall;
    logic [RADICAND_W-1:0] radicand;
    logic                  root_valid;
    logic                  root_stall;
    logic [ROOT_W-1:0]     root;

    int mismatches;
    int pending;
    int cycle_count;
    int send_idle_pct;
    int stall_pct;
    int hold_left;

    logic [RADICAND_W-1:0] corner_radicands [0:21];

    cordic_integer_square_root i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start_offset_wr_en   (start_offset_wr_en),
        .start_offset_wr_data (start_offset_wr_data),
        .radicand_valid       (radicand_valid),
        .radicand_stall       (radicand_stall),
        .radicand             (radicand),
        .root_valid           (root_valid),
        .root_stall           (root_stall),
        .root                 (root)
    );

    csqrt_root_checker i_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start_offset_wr_en   (start_offset_wr_en),
        .start_offset_wr_data (start_offset_wr_data),
        .radicand_valid       (radicand_valid),
        .radicand_stall       (radicand_stall),
        .radicand             (radicand),
        .root_valid           (root_valid),
        .root_stall           (root_stall),
        .root                 (root),
        .mismatches           (mismatches),
        .pending              (pending)
    );

    always #4 clk = ~clk;

    // Offers one item after a random number of idle cycles and returns at the
    // rising edge where it is accepted.
    task automatic send_radicand(input logic [RADICAND_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            radicand_valid <= 1'b0;
            @(negedge clk);
        end
        radicand_valid <= 1'b1;
        radicand       <= value;
        do begin
            @(posedge clk);
        end while (radicand_stall);
    endtask

    task automatic drain_roots();
        @(negedge clk);
        radicand_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_offset(input logic [RADICAND_W-1:0] value);
        drain_roots();
        @(negedge clk);
        start_offset_wr_en   <= 1'b1;
        start_offset_wr_data <= value;
        @(negedge clk);
        start_offset_wr_en   <= 1'b0;
    endtask

    task automatic run_items(input int count, input int send_pct, input int recv_pct,
                             input bit with_hold);
        logic [RADICAND_W-1:0] value;
        logic [ROOT_W-1:0]     base;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: value = $urandom;
                1: value = $urandom >> $urandom_range(31);
                2: begin
                    // Perfect squares and their neighbors sit on the correction edge.
                    base  = ROOT_W'($urandom_range(65535));
                    value = base * base + $urandom_range(2) - 1;
                end
                default: value = $urandom_range(255);
            endcase
            send_radicand(value);
            if (with_hold && n == count / 3) begin
                hold_left = 160;
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off while hold_left runs down.
    initial begin
        root_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                root_stall <= 1'b1;
                hold_left--;
            end
            else begin
                root_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        rst_n                = 1'b0;
        start_offset_wr_en   = 1'b0;
        start_offset_wr_data = '0;
        radicand_valid       = 1'b0;
        radicand             = '0;
        send_idle_pct        = 0;
        stall_pct            = 0;
        hold_left            = 0;
        corner_radicands = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                             32'h0000_0004, 32'h0000_0008, 32'h0000_000F, 32'h0000_0010,
                             32'h0000_0011, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFE_0001,
                             32'hFFFE_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000,
                             32'h3FFF_FFFF, 32'h0001_0000, 32'h0000_FFFF, 32'hAAAA_AAAA,
                             32'h5555_5555, 32'h0000_FE01};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Reset offset first, with corners back to back.
        for (int n = 0; n < 22; n++) begin
            send_radicand(corner_radicands[n]);
        end
        run_items(300, 45, 0, 1'b0);
        run_items(300, 0, 45, 1'b0);
        run_items(200, 9, 9, 1'b1);

        // Mismatched and extreme offsets: roots may be off or wrap.
        write_offset('0);
        run_items(60, 45, 45, 1'b0);
        write_offset('1);
        run_items(60, 0, 0, 1'b0);
        write_offset($urandom);
        run_items(60, 9, 9, 1'b0);
        write_offset(OFFSET_RESET - 32'd1000);
        run_items(40, 45, 0, 1'b0);

        write_offset(OFFSET_RESET);
        for (int n = 0; n < 22; n++) begin
            send_radicand(corner_radicands[n]);
        end
        run_items(100, 0, 45, 1'b1);

        drain_roots();
        repeat (30) @(negedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
